// File: hdl/ssplit_pkg.sv
package ssplit_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_STRING = 2'd1,
        MODE_BLOCK  = 2'd2,
        MODE_LINE   = 2'd3
    } lex_mode_t;

    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef struct packed {
        logic        swallow;
        lex_mode_t   mode;
        logic [7:0]  prev_raw;
        logic        prev_valid;
        logic        open;
        logic        has_text;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        swallow:    1'b0,
        mode:       MODE_NORMAL,
        prev_raw:   8'h00,
        prev_valid: 1'b0,
        open:       1'b0,
        has_text:   1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       stmt_end;
        logic       stmt_blank;
        logic       run_last;
    } result_t;

    typedef struct packed {
        lex_state_t st;
        logic       emit;
        result_t    res;
    } judge_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

// File: hdl/ssplit_if.sv
interface ssplit_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_script;

    modport source (output valid, output in_byte, output end_of_script, input ready);
    modport sink (input valid, input in_byte, input end_of_script, output ready);
endinterface

interface ssplit_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stmt_end;
    logic       stmt_blank;
    logic       run_last;

    modport source (
        output valid, output out_byte, output byte_valid, output stmt_end,
        output stmt_blank, output run_last, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input stmt_end,
        input stmt_blank, input run_last, output ready
    );
endinterface

// File: hdl/sql_statement_splitter.sv
// SQL script statement splitter.
// in_ch carries one raw script byte per transaction, end_of_script set on the
// final byte. out_ch carries the kept bytes, a stmt_end mark on each
// semicolon outside a string, and a separate end mark (byte_valid low) for an
// unterminated statement at end of script; stmt_blank, set only on that end
// mark, flags a statement that held only space, tab, LF or CR. run_last
// marks the last transaction caused by one input byte. Comments are dropped;
// one byte is held for lookahead, so a byte's result appears when the next
// byte (or end_of_script) arrives.
// Throughput: one byte per cycle while out_ch takes each result and each
// byte makes at most one; the final byte can make up to three, which drain
// at one per cycle as out_ch takes them; in_ch waits while two or more remain.
// Reset clears the lexer state, the held byte and the result count (not the
// buffer data); the lexer also returns to reset after each end_of_script byte.
// When out_ch stalls, results hold in the buffer; in_ch.ready is high only
// while the buffer is empty or holds one result that out_ch takes that cycle.
module sql_statement_splitter
    import ssplit_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    ssplit_in_if.sink      in_ch,
    ssplit_out_if.source   out_ch
);

    lex_state_t  state_reg, state_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [1:0]  cnt_reg, cnt_next;
    result_t     res_reg [3];
    result_t     res_next [3];

    judge_t      j_held, j_last;
    lex_state_t  st_mid;
    result_t     cand [3];
    logic        cand_v [3];
    result_t     list [3];
    logic [1:0]  n_res;
    logic        take, pop;

    function automatic judge_t judge(lex_state_t s, logic [7:0] c, logic [7:0] nx);
        judge_t j;
        logic   keep;
        j = '{st: s, emit: 1'b0, res: '0};
        keep = 1'b0;
        if (s.swallow) begin
            j.st.swallow = 1'b0;
        end else if (s.mode == MODE_NORMAL) begin
            if (c == CH_DASH && nx == CH_DASH) begin
                j.st.mode = MODE_LINE;
                j.st.swallow = 1'b1;
            end else if (c == CH_SLASH && nx == CH_STAR) begin
                j.st.mode = MODE_BLOCK;
                j.st.swallow = 1'b1;
            end else begin
                keep = 1'b1;
            end
        end else if (s.mode == MODE_BLOCK) begin
            if (c == CH_STAR && nx == CH_SLASH) begin
                j.st.mode = MODE_NORMAL;
                j.st.swallow = 1'b1;
            end
        end else if (s.mode == MODE_LINE) begin
            if (c == CH_LF) begin
                j.st.mode = MODE_NORMAL;
            end
        end else begin
            keep = 1'b1;
        end
        if (keep) begin
            // an escaped quote leaves the string state alone
            if (c == CH_QUOTE && !(s.prev_valid && s.prev_raw == CH_BACKSLASH)) begin
                j.st.mode = (s.mode == MODE_STRING) ? MODE_NORMAL : MODE_STRING;
            end
            j.st.open = 1'b1;
            if (!is_space(c)) begin
                j.st.has_text = 1'b1;
            end
            j.emit = 1'b1;
            j.res.out_byte = c;
            j.res.byte_valid = 1'b1;
            if (j.st.mode == MODE_NORMAL && c == CH_SEMI) begin
                j.res.stmt_end = 1'b1;
                j.st.open = 1'b0;
                j.st.has_text = 1'b0;
            end
        end
        j.st.prev_raw = c;
        j.st.prev_valid = 1'b1;
        return j;
    endfunction

    assign take = in_ch.valid && in_ch.ready;
    assign pop  = out_ch.valid && out_ch.ready;

    assign in_ch.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ch.ready);

    always_comb
    begin
        j_held = judge(state_reg, held_byte_reg, in_ch.in_byte);
        st_mid = held_valid_reg ? j_held.st : state_reg;
        j_last = judge(st_mid, in_ch.in_byte, CH_NUL);

        cand[0]   = j_held.res;
        cand_v[0] = held_valid_reg && j_held.emit;
        cand[1]   = j_last.res;
        cand_v[1] = in_ch.end_of_script && j_last.emit;
        cand[2]   = '{out_byte: 8'h00, byte_valid: 1'b0, stmt_end: 1'b1,
                      stmt_blank: !j_last.st.has_text, run_last: 1'b0};
        cand_v[2] = in_ch.end_of_script && j_last.st.open;

        // pack the produced results to the front
        n_res = 2'd0;
        for (int i = 0; i < 3; i++) begin
            list[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (cand_v[i]) begin
                list[n_res] = cand[i];
                n_res = n_res + 2'd1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            list[i].run_last = (2'(i) + 2'd1 == n_res);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        if (take) begin
            if (in_ch.end_of_script) begin
                state_next      = LEX_RESET;
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
            end else begin
                state_next      = st_mid;
                held_byte_next  = in_ch.in_byte;
                held_valid_next = 1'b1;
            end
            res_next = list;
            cnt_next = n_res;
        end else if (pop) begin
            // advance the buffer
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= LEX_RESET;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end else begin
            state_reg      <= state_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_ch.valid      = (cnt_reg != 2'd0);
    assign out_ch.out_byte   = res_reg[0].out_byte;
    assign out_ch.byte_valid = res_reg[0].byte_valid;
    assign out_ch.stmt_end   = res_reg[0].stmt_end;
    assign out_ch.stmt_blank = res_reg[0].stmt_blank;
    assign out_ch.run_last   = res_reg[0].run_last;

endmodule

// File: bench/tb_top.sv
module tb_top
    import ssplit_pkg::*;
();

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_BYTES = 230;
    localparam int MAX_REPORTS  = 10;

    // one row of the directed table; rs holds typed results when typed is set
    typedef struct packed {
        logic [7:0]      b;
        logic            eos;
        logic            typed;
        logic [1:0]      n;
        result_t [0:2]   rs;
    } row_t;

    localparam result_t        NONE  = '0;
    localparam result_t [0:2]  NO_RS = '0;

    localparam int N_DIRECTED = 27;
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // typed: held byte gives nothing, then semicolon at end of script
        '{8'h61, 1'b0, 1'b1, 2'd0, NO_RS},
        '{CH_SEMI, 1'b1, 1'b1, 2'd2, '{'{8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
                                       '{CH_SEMI, 1'b1, 1'b1, 1'b0, 1'b1}, NONE}},
        // typed: whitespace-only script, then byte extremes
        '{CH_SPACE, 1'b1, 1'b1, 2'd2, '{'{CH_SPACE, 1'b1, 1'b0, 1'b0, 1'b0},
                                        '{CH_NUL, 1'b0, 1'b1, 1'b1, 1'b1}, NONE}},
        '{8'hFF, 1'b1, 1'b1, 2'd2, '{'{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0},
                                     '{CH_NUL, 1'b0, 1'b1, 1'b0, 1'b1}, NONE}},
        '{CH_NUL, 1'b1, 1'b1, 2'd2, '{'{CH_NUL, 1'b1, 1'b0, 1'b0, 1'b0},
                                      '{CH_NUL, 1'b0, 1'b1, 1'b0, 1'b1}, NONE}},
        // line comment through LF, then semicolon
        '{CH_DASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_DASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_LF, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_SEMI, 1'b1, 1'b0, 2'd0, NO_RS},
        // empty block comment, then string with comment opener, escaped quote
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_STAR, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_SLASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_DASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_DASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_SEMI, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_QUOTE, 1'b1, 1'b0, 2'd0, NO_RS},
        // lone dash as last byte: lookahead is zero, so it is kept
        '{CH_DASH, 1'b1, 1'b0, 2'd0, NO_RS},
        // comment-only script: no end mark
        '{CH_DASH, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_DASH, 1'b1, 1'b0, 2'd0, NO_RS},
        // semicolon statement, then trailing tab-only statement
        '{CH_SEMI, 1'b0, 1'b0, 2'd0, NO_RS},
        '{CH_TAB, 1'b1, 1'b0, 2'd0, NO_RS},
        // quote as first byte opens a string left open at end of script
        '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_RS},
        '{8'h78, 1'b1, 1'b0, 2'd0, NO_RS}
    };

    logic clk = 1'b0;
    logic rst_n;

    ssplit_in_if  in_ch ();
    ssplit_out_if out_ch ();

    sql_statement_splitter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // lexer shadow state
    logic [7:0]  lx_held;
    logic        lx_held_ok;
    logic        lx_swallow;
    lex_mode_t   lx_mode;
    logic [7:0]  lx_prev;
    logic        lx_prev_ok;
    logic        lx_open;
    logic        lx_text;

    result_t     step_res[$];
    result_t     kept_q[$];
    logic [7:0]  script_q[$];

    int n_bytes   = 0;
    int n_scripts = 0;
    int n_results = 0;
    int n_ends    = 0;
    int n_errors  = 0;
    int burst_left;
    int cycles    = 0;
    int rx_cycle  = 0;
    int rx_mode   = 0;
    result_t got;
    result_t want;

    function automatic void clear_lexer();
        lx_held    = CH_NUL;
        lx_held_ok = 1'b0;
        lx_swallow = 1'b0;
        lx_mode    = MODE_NORMAL;
        lx_prev    = CH_NUL;
        lx_prev_ok = 1'b0;
        lx_open    = 1'b0;
        lx_text    = 1'b0;
    endfunction

    function automatic void add_char(logic [7:0] c);
        script_q.insert(script_q.size(), c);
    endfunction

    function automatic void add_expect(result_t r);
        kept_q.insert(kept_q.size(), r);
    endfunction

    function automatic void note(logic [7:0] b, logic bv, logic e, logic bl);
        result_t r;
        r.out_byte   = bv ? b : CH_NUL;
        r.byte_valid = bv;
        r.stmt_end   = e;
        r.stmt_blank = e & bl;
        r.run_last   = 1'b0;
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void keep_char(logic [7:0] c);
        if (c == CH_QUOTE && !(lx_prev_ok && lx_prev == CH_BACKSLASH))
            lx_mode = (lx_mode == MODE_STRING) ? MODE_NORMAL : MODE_STRING;
        lx_open = 1'b1;
        if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR))
            lx_text = 1'b1;
        if (lx_mode == MODE_NORMAL && c == CH_SEMI)
        begin
            note(c, 1'b1, 1'b1, 1'b0);
            lx_open = 1'b0;
            lx_text = 1'b0;
        end
        else
            note(c, 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void judge_char(logic [7:0] c, logic [7:0] nx);
        if (lx_swallow)
            lx_swallow = 1'b0;
        else
        begin
            case (lx_mode)
                MODE_NORMAL:
                begin
                    if (c == CH_DASH && nx == CH_DASH)
                    begin
                        lx_mode    = MODE_LINE;
                        lx_swallow = 1'b1;
                    end
                    else if (c == CH_SLASH && nx == CH_STAR)
                    begin
                        lx_mode    = MODE_BLOCK;
                        lx_swallow = 1'b1;
                    end
                    else
                        keep_char(c);
                end
                MODE_BLOCK:
                begin
                    if (c == CH_STAR && nx == CH_SLASH)
                    begin
                        lx_mode    = MODE_NORMAL;
                        lx_swallow = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (c == CH_LF)
                        lx_mode = MODE_NORMAL;
                end
                default:
                    keep_char(c);
            endcase
        end
        lx_prev    = c;
        lx_prev_ok = 1'b1;
    endfunction

    // results caused by one accepted byte land in step_res
    function automatic void lex_step(logic [7:0] b, logic eos);
        step_res.delete();
        if (lx_held_ok)
            judge_char(lx_held, b);
        lx_held    = b;
        lx_held_ok = 1'b1;
        if (eos)
        begin
            judge_char(lx_held, CH_NUL);
            if (lx_open)
                note(CH_NUL, 1'b0, 1'b1, !lx_text);
            clear_lexer();
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].run_last = 1'b1;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0:  return CH_DASH;
            1:  return CH_SLASH;
            2:  return CH_STAR;
            3:  return CH_LF;
            4:  return CH_CR;
            5:  return CH_TAB;
            6:  return CH_SPACE;
            7:  return CH_QUOTE;
            8:  return CH_BACKSLASH;
            9:  return CH_SEMI;
            10, 11, 12: return 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_letters(int cnt);
        repeat (cnt) add_char(8'h61 + 8'($urandom_range(0, 25)));
    endfunction

    function automatic void add_noise(int cnt);
        repeat (cnt) add_char(pick_char());
    endfunction

    // mostly well-formed tokens with random content; some raw noise
    function automatic void build_script();
        script_q.delete();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                0, 1: add_letters($urandom_range(1, 5));
                2:
                    repeat ($urandom_range(1, 3))
                        case ($urandom_range(0, 3))
                            0: add_char(CH_SPACE);
                            1: add_char(CH_TAB);
                            2: add_char(CH_LF);
                            default: add_char(CH_CR);
                        endcase
                3: add_char(CH_SEMI);
                4:
                begin
                    add_char(CH_QUOTE);
                    add_noise($urandom_range(0, 5));
                    add_char(CH_QUOTE);
                end
                5:
                begin
                    add_char(CH_DASH);
                    add_char(CH_DASH);
                    add_noise($urandom_range(0, 5));
                    add_char(CH_LF);
                end
                6:
                begin
                    add_char(CH_SLASH);
                    add_char(CH_STAR);
                    add_noise($urandom_range(0, 5));
                    add_char(CH_STAR);
                    add_char(CH_SLASH);
                end
                7:
                begin
                    add_char(CH_QUOTE);
                    add_char(CH_BACKSLASH);
                    add_char(CH_QUOTE);
                    add_letters($urandom_range(0, 2));
                    add_char(CH_QUOTE);
                end
                default: add_noise($urandom_range(1, 3));
            endcase
        end
    endfunction

    task automatic send_row(input row_t r);
        int gap;
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= r.b;
        in_ch.end_of_script <= r.eos;
        do
            @(posedge clk);
        while (!in_ch.ready);
        lex_step(r.b, r.eos);
        if (r.typed)
        begin
            for (int i = 0; i < r.n; i++)
                add_expect(r.rs[i]);
        end
        else
        begin
            foreach (step_res[i])
                add_expect(step_res[i]);
        end
        n_bytes++;
        if (r.eos)
            n_scripts++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic void report(string what);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
        begin
            $display("%s at cycle %0d: want byte=%02h bv=%b end=%b blank=%b last=%b",
                     what, cycles, want.out_byte, want.byte_valid, want.stmt_end,
                     want.stmt_blank, want.run_last);
            $display("    got byte=%02h bv=%b end=%b blank=%b last=%b",
                     got.out_byte, got.byte_valid, got.stmt_end, got.stmt_blank,
                     got.run_last);
        end
    endfunction

    // check results, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.out_byte, out_ch.byte_valid, out_ch.stmt_end,
                   out_ch.stmt_blank, out_ch.run_last};
            n_results++;
            if (got.stmt_end)
                n_ends++;
            if (kept_q.size() == 0)
            begin
                want = NONE;
                report("unexpected transaction");
            end
            else
            begin
                want = kept_q.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid
                    || got.stmt_end !== want.stmt_end || got.stmt_blank !== want.stmt_blank
                    || got.run_last !== want.run_last)
                    report("mismatch");
            end
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= ((rx_cycle % 16) < 5);
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", kept_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int rand_bytes;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.end_of_script <= 1'b0;
        rst_n               <= 1'b0;
        clear_lexer();
        rand_bytes = 0;
        burst_left = $urandom_range(1, 24);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_row(DIRECTED[i]);

        while (rand_bytes < RANDOM_BYTES)
        begin
            row_t rr;
            build_script();
            foreach (script_q[i])
            begin
                rr     = '0;
                rr.b   = script_q[i];
                rr.eos = (i == script_q.size() - 1);
                send_row(rr);
            end
            rand_bytes += script_q.size();
        end
        in_ch.valid <= 1'b0;

        // drain, then give stray transactions a chance to show up
        while (kept_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes in %0d scripts; checked %0d transactions, %0d statement ends",
                 n_bytes, n_scripts, n_results, n_ends);
        $display("covered line and block comments, strings with escaped quotes, blank statements");
        if (n_errors == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d failures", n_errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ssplit_pkg.sv
hdl/ssplit_if.sv
hdl/sql_statement_splitter.sv
bench/tb_top.sv
